[src/tkps_pkg.sv]
// ----------------------------------------------------------------------------
// tkps_pkg
// Shared constants for the top-k pair selector.
// ----------------------------------------------------------------------------
package tkps_pkg;
  localparam int SCORE_W = 17;
  localparam int RAW_W   = 18;
  localparam int K_W     = 11;
  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;
  localparam logic [K_W-1:0] K_RESET = 11'd1000;
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_READ  = 1'b1;
endpackage

[src/tkps_ram.sv]
// ----------------------------------------------------------------------------
// tkps_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module tkps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[src/top_k_pair_selector_top.sv]
// ----------------------------------------------------------------------------
// top_k_pair_selector_top
// Keeps the k best-scoring record pairs in a min-heap held in RAM.
// ----------------------------------------------------------------------------
// Each item is handled on its own, and the next one is taken only after the
// result has been taken. A read of a held slot reads one RAM word. A read past
// the held count or an offer with a negative score is answered without a RAM
// access. An offer first reads the root, and a full heap turns it away unless
// it scores strictly above the minimum. An insert walks up from the new slot,
// reading each parent and moving it down while it scores above the new item;
// the item that fills the heap then reads the root again for the threshold.
// A replacement of the minimum walks down, reading the left and then the right
// child at each level, and then reads the root again. The single RAM port,
// which is shared by reads and writes, paces these steps. A result that waits
// for ready holds off the next item.
module top_k_pair_selector_top
  import tkps_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int ID_BITS  = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [K_W-1:0]              cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [ID_BITS-1:0]          first_id,
  input  logic [ID_BITS-1:0]          second_id,
  input  logic signed [RAW_W-1:0]     score,
  input  logic [9:0]                  entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic [SCORE_W-1:0]          threshold,
  output logic [K_W-1:0]              held_count,
  output logic [ID_BITS-1:0]          entry_low_id,
  output logic [ID_BITS-1:0]          entry_high_id,
  output logic [SCORE_W-1:0]          entry_score,
  output logic                        entry_valid
);
  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = AW + 1;
  localparam int EW  = 2 * ID_BITS + SCORE_W;
  localparam int IXW = (CW > 10) ? CW : 10;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR,
    S_DN_CMP, S_WR, S_RD_WAIT, S_RD_DONE, S_KTH_RD, S_KTH_DONE
  } state_t;

  state_t state;
  logic [K_W-1:0] k_wanted;
  logic [CW-1:0] kept_count;
  logic [SCORE_W-1:0] kth_score;
  logic [EW-1:0] item;          // pending entry: {high, low, score}
  logic [CW-1:0] pos, child;
  logic [EW-1:0] left_e;
  logic [CW-1:0] n_eff;
  logic [9:0] idx_r;
  logic sift_down_r;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  tkps_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Effective k: zero acts as one, and it never goes above the capacity.
  logic [CW:0] k_eff;
  always_comb begin
    if (k_wanted == '0) begin
      k_eff = (CW+1)'(1);
    end else if ((CW+1+K_W)'(k_wanted) > (CW+1+K_W)'(CAPACITY)) begin
      k_eff = (CW+1)'(CAPACITY);
    end else begin
      k_eff = (CW+1)'(k_wanted);
    end
  end

  logic [SCORE_W-1:0] in_s;
  assign in_s = (score[RAW_W-2:0] > (RAW_W-1)'(SCORE_ONE)) ? SCORE_ONE
              : SCORE_W'(score[RAW_W-2:0]);

  logic [SCORE_W-1:0] item_s, rd_s, left_s;
  assign item_s = item[SCORE_W-1:0];
  assign rd_s   = ram_rdata[SCORE_W-1:0];
  assign left_s = left_e[SCORE_W-1:0];

  logic [CW-1:0] parent;
  assign parent = (pos - CW'(1)) >> 1;
  logic [CW:0] lchild;
  assign lchild = {pos, 1'b1};

  // In S_DN_CMP the left child sits in left_e and the right child is on the
  // RAM output. The right one wins only when it exists and is strictly smaller.
  logic dn_right;
  logic [EW-1:0] dn_e;
  logic [SCORE_W-1:0] dn_s;
  assign dn_right = ((CW+1)'(child) + (CW+1)'(1) < (CW+1)'(n_eff)) && (rd_s < left_s);
  assign dn_e = dn_right ? ram_rdata : left_e;
  assign dn_s = dn_e[SCORE_W-1:0];

  always_comb begin
    ram_we = 1'b0;
    ram_addr = '0;
    ram_wdata = item;
    case (state)
      S_DEC: begin
        ram_addr = '0;
      end
      S_UP_RD: begin
        ram_addr = AW'(parent);
      end
      S_DN_RDL: begin
        ram_addr = AW'(lchild);
      end
      S_DN_RDR: begin
        ram_addr = AW'(lchild + (CW+1)'(1));
      end
      S_UP_CMP: begin
        if (rd_s > item_s) begin
          ram_we = 1'b1;
          ram_addr = AW'(pos);
          ram_wdata = ram_rdata;
        end
      end
      S_DN_CMP: begin
        ram_addr = AW'(pos);
        ram_wdata = dn_e;
        if (dn_s < item_s) begin
          ram_we = 1'b1;
        end
      end
      S_WR: begin
        ram_we = 1'b1;
        ram_addr = AW'(pos);
      end
      S_RD_WAIT: begin
        ram_addr = AW'(idx_r);
      end
      S_KTH_RD: begin
        ram_addr = '0;
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k_wanted <= K_RESET;
      kept_count <= '0;
      kth_score <= '0;
      out_valid <= 1'b0;
      accepted <= 1'b0;
      entry_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        k_wanted <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            idx_r <= entry_index;
            item <= {(first_id < second_id) ? second_id : first_id,
                     (first_id < second_id) ? first_id : second_id, in_s};
            entry_low_id <= '0;
            entry_high_id <= '0;
            entry_score <= '0;
            entry_valid <= 1'b0;
            accepted <= 1'b0;
            if (opcode == OP_READ) begin
              if (IXW'(entry_index) < IXW'(kept_count)) begin
                state <= S_RD_WAIT;
              end else begin
                out_valid <= 1'b1;
              end
            end else if (score[RAW_W-1]) begin
              out_valid <= 1'b1;
            end else begin
              state <= S_DEC;
            end
          end
        end
        S_DEC: begin
          // RAM root read is under way; decide insert or replace.
          if ((CW+1)'(kept_count) < k_eff) begin
            sift_down_r <= 1'b0;
            pos <= kept_count;
            kept_count <= kept_count + CW'(1);
            state <= (kept_count == '0) ? S_WR : S_UP_RD;
          end else begin
            sift_down_r <= 1'b1;
            n_eff <= kept_count;
            pos <= '0;
            state <= S_KTH_DONE;
          end
        end
        S_KTH_DONE: begin
          if (!sift_down_r) begin
            kth_score <= rd_s;
            out_valid <= 1'b1;
            accepted <= 1'b1;
            state <= S_IDLE;
          end else if (item_s > rd_s) begin
            state <= S_DN_RDL;
          end else begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_UP_RD: begin
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (rd_s > item_s) begin
            pos <= parent;
            state <= (parent == '0) ? S_WR : S_UP_RD;
          end else begin
            state <= S_WR;
          end
        end
        S_DN_RDL: begin
          if (lchild >= (CW+1)'(n_eff)) begin
            state <= S_WR;
          end else begin
            child <= CW'(lchild);
            state <= S_DN_RDR;
          end
        end
        S_DN_RDR: begin
          left_e <= ram_rdata;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_s < item_s) begin
            pos <= dn_right ? child + CW'(1) : child;
            state <= S_DN_RDL;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          if (sift_down_r) begin
            state <= S_KTH_RD;
          end else if ((CW+1)'(kept_count) == k_eff) begin
            state <= S_KTH_RD;
          end else begin
            out_valid <= 1'b1;
            accepted <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_KTH_RD: begin
          sift_down_r <= 1'b0;
          state <= S_KTH_DONE;
        end
        S_RD_WAIT: begin
          state <= S_RD_DONE;
        end
        S_RD_DONE: begin
          entry_score <= rd_s;
          entry_low_id <= ram_rdata[SCORE_W +: ID_BITS];
          entry_high_id <= ram_rdata[SCORE_W+ID_BITS +: ID_BITS];
          entry_valid <= 1'b1;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign threshold = kth_score;
  assign held_count = K_W'(kept_count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(kept_count) <= (CW+1)'(CAPACITY))
    else $error("held count above capacity");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_IDLE)
    else $error("result shown while work continues");
  a_read_no_accept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_valid) |-> !accepted)
    else $error("read item flagged as accepted");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    kept_count != $past(kept_count) |-> kept_count == $past(kept_count) + CW'(1))
    else $error("held count moved by other than one");
endmodule
